/* sv/rpm_pkg.sv */
// ----------------------------------------------------------------------------
// rpm_pkg
// Shared widths, register indexes and controller/datapath signal groups of the
// recursive phasor I/Q mixer.
// ----------------------------------------------------------------------------
package rpm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_BITS  = 30;
  localparam int COUNT_W    = 24;
  localparam int PHASE_W    = 32;

  localparam int SQRT_ITERS = PHASE_W;
  localparam int DIV_ITERS  = FRAC_BITS + 1;
  localparam int ITER_W     = $clog2((SQRT_ITERS > DIV_ITERS) ? SQRT_ITERS : DIV_ITERS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PHASE_W-1:0]  phase_t;

  localparam cfg_idx_t REG_ROTATE = cfg_idx_t'(0);
  localparam cfg_idx_t REG_COS    = cfg_idx_t'(1);
  localparam cfg_idx_t REG_SIN    = cfg_idx_t'(2);
  localparam cfg_idx_t REG_BLOCK  = cfg_idx_t'(3);

  typedef struct packed {
    logic capture;
    logic mul;
    logic sum;
    logic square;
    logic sq_add;
    logic sqrt_step;
    logic div_load;
    logic div_step;
    logic div_sin;
    logic sin_wb;
    logic unit;
  } cmd_t;

  typedef struct packed {
    logic renorm;
    logic mag_zero;
  } stat_t;

endpackage

/* sv/rpm_ctrl.sv */
// ----------------------------------------------------------------------------
// rpm_ctrl
// Sequencer of the mixer: item capture, multiply, round and output, then the
// optional renormalization (square, square root, two divisions or unit reset).
// ----------------------------------------------------------------------------
module rpm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rpm_pkg::stat_t stat,
  output rpm_pkg::cmd_t  cmd
);
  import rpm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_SQ, S_ADD, S_SQRT,
    S_DSET_C, S_DIV_C, S_DSET_S, S_DIV_S, S_WB_S
  } state_t;

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (out_free) begin
          cmd.sum       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = stat.renorm ? S_SQ : S_IDLE;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        cmd.sq_add = 1'b1;
        cnt_nxt    = ITER_W'(SQRT_ITERS - 1);
        state_nxt  = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_DSET_C;
      end
      S_DSET_C: begin
        if (stat.mag_zero) begin
          cmd.unit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.div_load = 1'b1;
          cnt_nxt      = ITER_W'(DIV_ITERS - 1);
          state_nxt    = S_DIV_C;
        end
      end
      S_DIV_C: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_DSET_S;
      end
      S_DSET_S: begin
        cmd.div_load = 1'b1;
        cmd.div_sin  = 1'b1;
        cnt_nxt      = ITER_W'(DIV_ITERS - 1);
        state_nxt    = S_DIV_S;
      end
      S_DIV_S: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_WB_S;
      end
      S_WB_S: begin
        cmd.sin_wb = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_in_renorm: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.sqrt_step || cmd.div_step || cmd.div_load))
    else $error("item accepted during renormalization");

  a_result_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_SUM))
    else $error("result raised outside the round stage");

  a_renorm_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM && out_free && stat.renorm) |=> state_r == S_SQ)
    else $error("renormalization skipped");

  a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT && cnt_r == '0) |=> state_r == S_DSET_C)
    else $error("square root pass length wrong");
`endif

endmodule

/* sv/rpm_datapath.sv */
// ----------------------------------------------------------------------------
// rpm_datapath
// Configuration registers, phasor state, block counter, multipliers, rounding
// with saturation, bit-serial square root and restoring divider.
// ----------------------------------------------------------------------------
module rpm_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  rpm_pkg::cmd_t      cmd,
  output rpm_pkg::stat_t     stat,
  input  logic               cfg_we,
  input  rpm_pkg::cfg_idx_t  cfg_index,
  input  rpm_pkg::cfg_data_t cfg_data,
  input  rpm_pkg::sample_t   in_sample_i,
  input  rpm_pkg::sample_t   in_sample_q,
  output rpm_pkg::sample_t   out_i,
  output rpm_pkg::sample_t   out_q
);
  import rpm_pkg::*;

  localparam int PROD_W = SAMPLE_W + PHASE_W;
  localparam int SAW    = PROD_W + 2;
  localparam int RPW    = 2 * PHASE_W;
  localparam int RAW    = RPW + 2;
  localparam int VW     = 2 * PHASE_W;
  localparam int SRW    = PHASE_W + 3;
  localparam int NW     = PHASE_W + FRAC_BITS;
  localparam int QB     = DIV_ITERS;

  localparam logic signed [SAW-1:0] RND_S = SAW'(1) << (FRAC_BITS - 1);
  localparam logic signed [RAW-1:0] RND_R = RAW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SAW-1:0] SMAX = {{(SAW-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAW-1:0] SMIN = {{(SAW-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [RAW-1:0] PMAX = {{(RAW-PHASE_W+1){1'b0}}, {(PHASE_W-1){1'b1}}};
  localparam logic signed [RAW-1:0] PMIN = {{(RAW-PHASE_W+1){1'b1}}, {(PHASE_W-1){1'b0}}};
  localparam phase_t ONE = phase_t'(1) << FRAC_BITS;

  logic                rot_en_r;
  phase_t              cos_step_r, sin_step_r;
  logic [COUNT_W-1:0]  blk_len_r, blk_cnt_r;
  phase_t              c_r, s_r;
  sample_t             si_r, sq_r, out_i_r, out_q_r;
  logic signed [PROD_W-1:0] p_ic_r, p_qs_r, p_qc_r, p_is_r;
  logic signed [RPW-1:0]    pr_cc_r, pr_ss_r, pr_sc_r, pr_cs_r;
  logic [VW-1:0]       v_r;
  logic [SRW-1:0]      rem_r;
  logic [PHASE_W-1:0]  root_r;
  logic [PHASE_W-1:0]  drem_r;
  logic [QB-1:0]       dq_r;

  phase_t              mb_a, mb_b;
  logic signed [SAW-1:0] acc_i, acc_q, sh_i, sh_q;
  logic signed [RAW-1:0] acc_c, acc_s, sh_c, sh_s;
  sample_t             rnd_i, rnd_q;
  phase_t              rot_c, rot_s;
  logic [COUNT_W-1:0]  cnt_inc, limit;
  logic                cfg_unit;
  logic [SRW-1:0]      rem_sh, trial;
  logic                sq_ge;
  phase_t              div_x;
  logic [PHASE_W-1:0]  ax;
  logic [NW-1:0]       num;
  logic [PHASE_W:0]    dsh, ddiff;
  logic                d_ge;
  phase_t              qv;

  function automatic sample_t sat_s(input logic signed [SAW-1:0] x);
    if (x > SMAX) return SMAX[SAMPLE_W-1:0];
    if (x < SMIN) return SMIN[SAMPLE_W-1:0];
    return x[SAMPLE_W-1:0];
  endfunction

  function automatic phase_t sat_p(input logic signed [RAW-1:0] x);
    if (x > PMAX) return PMAX[PHASE_W-1:0];
    if (x < PMIN) return PMIN[PHASE_W-1:0];
    return x[PHASE_W-1:0];
  endfunction

  // mixing and rotation rounding
  always_comb begin
    acc_i = SAW'(p_ic_r) - SAW'(p_qs_r) + RND_S;
    acc_q = SAW'(p_qc_r) + SAW'(p_is_r) + RND_S;
    sh_i  = acc_i >>> FRAC_BITS;
    sh_q  = acc_q >>> FRAC_BITS;
    rnd_i = sat_s(sh_i);
    rnd_q = sat_s(sh_q);
    acc_c = RAW'(pr_cc_r) - RAW'(pr_ss_r) + RND_R;
    acc_s = RAW'(pr_sc_r) + RAW'(pr_cs_r) + RND_R;
    sh_c  = acc_c >>> FRAC_BITS;
    sh_s  = acc_s >>> FRAC_BITS;
    rot_c = sat_p(sh_c);
    rot_s = sat_p(sh_s);
  end

  assign cnt_inc     = blk_cnt_r + 1'b1;
  assign limit       = (blk_len_r == '0) ? COUNT_W'(1) : blk_len_r;
  assign stat.renorm = (cnt_inc >= limit) || (cnt_inc == '0);
  assign stat.mag_zero = (root_r == '0);

  assign cfg_unit = cfg_we && ((cfg_index == REG_COS) || (cfg_index == REG_SIN));

  // multiplier operands: square pass reuses the c and s multipliers
  always_comb begin
    if (cmd.square) begin
      mb_a = c_r;
      mb_b = s_r;
    end else begin
      mb_a = cos_step_r;
      mb_b = sin_step_r;
    end
  end

  // square root recurrence, one root bit per step
  assign rem_sh = {rem_r[SRW-3:0], v_r[VW-1 -: 2]};
  assign trial  = {{(SRW-PHASE_W-2){1'b0}}, root_r, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  // restoring divider, one quotient bit per step
  assign div_x = cmd.div_sin ? s_r : c_r;
  assign ax    = div_x[PHASE_W-1] ? (~div_x + 1'b1) : div_x;
  assign num   = {ax, {FRAC_BITS{1'b0}}} + NW'(root_r >> 1);
  assign dsh   = {drem_r, dq_r[QB-1]};
  assign ddiff = dsh - {1'b0, root_r};
  assign d_ge  = (dsh >= {1'b0, root_r});
  assign qv    = phase_t'(dq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_en_r   <= 1'b1;
      cos_step_r <= ONE;
      sin_step_r <= '0;
      blk_len_r  <= COUNT_W'(4800);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTATE: rot_en_r   <= cfg_data[0];
        REG_COS:    cos_step_r <= cfg_data[PHASE_W-1:0];
        REG_SIN:    sin_step_r <= cfg_data[PHASE_W-1:0];
        REG_BLOCK:  blk_len_r  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r       <= ONE;
      s_r       <= '0;
      blk_cnt_r <= '0;
    end else begin
      if (cfg_unit || cmd.unit) begin
        c_r <= ONE;
        s_r <= '0;
      end else if (cmd.sum && rot_en_r) begin
        c_r <= rot_c;
        s_r <= rot_s;
      end else if (cmd.div_load && cmd.div_sin) begin
        c_r <= c_r[PHASE_W-1] ? -qv : qv;
      end else if (cmd.sin_wb) begin
        s_r <= s_r[PHASE_W-1] ? -qv : qv;
      end
      if (cmd.sum) blk_cnt_r <= stat.renorm ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      si_r <= in_sample_i;
      sq_r <= in_sample_q;
    end
    if (cmd.mul) begin
      p_ic_r  <= si_r * c_r;
      p_qs_r  <= sq_r * s_r;
      p_qc_r  <= sq_r * c_r;
      p_is_r  <= si_r * s_r;
      pr_sc_r <= s_r * cos_step_r;
      pr_cs_r <= c_r * sin_step_r;
    end
    if (cmd.mul || cmd.square) begin
      pr_cc_r <= c_r * mb_a;
      pr_ss_r <= s_r * mb_b;
    end
    if (cmd.sum) begin
      out_i_r <= rot_en_r ? rnd_i : si_r;
      out_q_r <= rot_en_r ? rnd_q : sq_r;
    end
    if (cmd.sq_add) begin
      v_r    <= {1'b0, pr_cc_r[RPW-2:0]} + {1'b0, pr_ss_r[RPW-2:0]};
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      v_r    <= {v_r[VW-3:0], 2'b00};
      rem_r  <= sq_ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[PHASE_W-2:0], sq_ge};
    end
    if (cmd.div_load) begin
      drem_r <= {1'b0, num[NW-1:QB]};
      dq_r   <= num[QB-1:0];
    end else if (cmd.div_step) begin
      drem_r <= d_ge ? ddiff[PHASE_W-1:0] : dsh[PHASE_W-1:0];
      dq_r   <= {dq_r[QB-2:0], d_ge};
    end
  end

  assign out_i = out_i_r;
  assign out_q = out_q_r;

endmodule

/* sv/recursive_phasor_iq_mixer_unit.sv */
// ----------------------------------------------------------------------------
// recursive_phasor_iq_mixer_unit
// Complex mixer: each I/Q item is multiplied by a recursively rotated unit
// phasor, rounded and saturated; the phasor is renormalized once per block.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid in_ready in_sample_i/q         | sink
//   out     | out_valid out_ready out_i out_q         | source
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data  | sink
//
// An item goes through capture, multiply (eight parallel products), then
// round and write the output register.
// After the last item of a block the renormalization runs the one-bit-a-step
// square root and the shared restoring divider.
// A held output stalls the next item in its round stage only.
// Synchronous active-low reset; cfg_ready is always high.
// ----------------------------------------------------------------------------
module recursive_phasor_iq_mixer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpm_pkg::sample_t   in_sample_i,
  input  rpm_pkg::sample_t   in_sample_q,
  output logic               out_valid,
  input  logic               out_ready,
  output rpm_pkg::sample_t   out_i,
  output rpm_pkg::sample_t   out_q,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  rpm_pkg::cfg_idx_t  cfg_index,
  input  rpm_pkg::cfg_data_t cfg_data
);
  import rpm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpm_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_sample_i (in_sample_i),
    .in_sample_q (in_sample_q),
    .out_i       (out_i),
    .out_q       (out_q)
  );

endmodule

/* tb/tb_recursive_phasor_iq_mixer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_recursive_phasor_iq_mixer_unit
// Self-checking bench for the recursive phasor I/Q mixer. A bit-exact
// predictor tracks the phasor, its rotation and per-block renormalization.
// Directed items cover sample extremes, saturation, pass-through, zero
// block length, extreme steps and a collapsing phasor. Randomly configured
// phases follow, with random gaps on both channels, a long output stall and
// a full drain pause. Each output item is checked against the predicted one.
// ----------------------------------------------------------------------------
module tb_recursive_phasor_iq_mixer_unit;
  import rpm_pkg::*;

  localparam int RENORM_CYCLES   = 2 + SQRT_ITERS + 2 * (DIV_ITERS + 1) + 1;
  localparam int SETTLE_CYCLES   = RENORM_CYCLES + 16;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int LONG_HOLD       = 300;
  localparam int RUN_LIMIT_NS    = 4_000_000;
  localparam phase_t PHASE_ONE   = 32'sd1 <<< FRAC_BITS;
  localparam cfg_data_t STEP_EXTREMES [6] = '{32'h4000_0000, 32'hC000_0000, 32'h0000_0000,
                                             32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};

  typedef logic signed [95:0] wide_t;
  typedef struct packed {
    sample_t i;
    sample_t q;
  } iq_t;

  class mixer_tracker;
    logic                rot_en;
    phase_t              cos_step;
    phase_t              sin_step;
    logic [COUNT_W-1:0]  blk_len;
    phase_t              ph_cos;
    phase_t              ph_sin;
    logic [COUNT_W-1:0]  blk_cnt;
    iq_t                 mixed_due[$];
    int                  errors;

    function new();
      rot_en   = 1'b1;
      cos_step = PHASE_ONE;
      sin_step = '0;
      blk_len  = COUNT_W'(4800);
      ph_cos   = PHASE_ONE;
      ph_sin   = '0;
      blk_cnt  = '0;
      errors   = 0;
    endfunction

    function longint clamp(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function wide_t mul(longint x, longint y);
      wide_t a, b;
      a = x;
      b = y;
      return a * b;
    endfunction

    function longint round_prod(wide_t p1, wide_t p2);
      wide_t acc;
      acc = p1 + p2 + (wide_t'(1) <<< (FRAC_BITS - 1));
      acc = acc >>> FRAC_BITS;
      return $signed(acc[63:0]);
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root, trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function phase_t unit_scale(longint x, logic [63:0] mag);
      logic [63:0] ax, quo;
      longint r;
      ax = (x < 0) ? -x : x;
      quo = ((ax << FRAC_BITS) + (mag >> 1)) / mag;
      if (quo > 64'h7FFF_FFFF) quo = 64'h8000_0000;
      r = (x < 0) ? -$signed(quo) : $signed(quo);
      return phase_t'(clamp(r, PHASE_W));
    endfunction

    function void renormalize();
      logic [63:0] mag;
      longint c, s;
      c = ph_cos;
      s = ph_sin;
      mag = int_sqrt($unsigned(c * c) + $unsigned(s * s));
      if (mag == 0) begin
        ph_cos = PHASE_ONE;
        ph_sin = '0;
      end else begin
        ph_cos = unit_scale(c, mag);
        ph_sin = unit_scale(s, mag);
      end
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t val);
      case (idx)
        REG_ROTATE: rot_en = val[0];
        REG_COS: begin
          cos_step = phase_t'(val);
          ph_cos   = PHASE_ONE;
          ph_sin   = '0;
        end
        REG_SIN: begin
          sin_step = phase_t'(val);
          ph_cos   = PHASE_ONE;
          ph_sin   = '0;
        end
        REG_BLOCK: blk_len = val[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(sample_t smp_i, sample_t smp_q);
      longint si, sq, c, s, oi, oq;
      logic [COUNT_W-1:0] limit;
      iq_t res;
      si = smp_i;
      sq = smp_q;
      if (rot_en) begin
        c = ph_cos;
        s = ph_sin;
        oi = clamp(round_prod(mul(si, c), -mul(sq, s)), SAMPLE_W);
        oq = clamp(round_prod(mul(sq, c), mul(si, s)), SAMPLE_W);
        ph_cos = phase_t'(clamp(round_prod(mul(c, cos_step), -mul(s, sin_step)), PHASE_W));
        ph_sin = phase_t'(clamp(round_prod(mul(s, cos_step), mul(c, sin_step)), PHASE_W));
      end else begin
        oi = si;
        oq = sq;
      end
      limit = (blk_len == 0) ? COUNT_W'(1) : blk_len;
      blk_cnt = blk_cnt + 1'b1;
      if (blk_cnt >= limit || blk_cnt == 0) begin
        renormalize();
        blk_cnt = '0;
      end
      res.i = sample_t'(oi);
      res.q = sample_t'(oq);
      mixed_due.push_back(res);
    endfunction

    function void check_mixed(sample_t got_i, sample_t got_q);
      iq_t want;
      if (mixed_due.size() == 0) begin
        $error("unexpected output item: out_i=%0d out_q=%0d", got_i, got_q);
        errors++;
        return;
      end
      want = mixed_due.pop_front();
      if (got_i !== want.i) begin
        $error("out_i: expected %0d, actual %0d", want.i, got_i);
        errors++;
      end
      if (got_q !== want.q) begin
        $error("out_q: expected %0d, actual %0d", want.q, got_q);
        errors++;
      end
    endfunction

    function int pending();
      return mixed_due.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  sample_t   in_sample_i;
  sample_t   in_sample_q;
  logic      out_valid;
  logic      out_ready;
  sample_t   out_i;
  sample_t   out_q;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  mixer_tracker tracker;
  int tx_idle_max = 4;
  int rx_idle_max = 4;
  int rx_hold     = 0;

  recursive_phasor_iq_mixer_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample_i (in_sample_i),
    .in_sample_q (in_sample_q),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_i       (out_i),
    .out_q       (out_q),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return sample_t'(16'h8000);
      1: return sample_t'(16'h7FFF);
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic feed(input sample_t si, input sample_t sq);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_sample_i <= si;
    in_sample_q <= sq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_sample(si, sq);
  endtask

  task automatic end_phase(input bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input cfg_data_t rot, input cfg_data_t cs,
                              input cfg_data_t sn, input cfg_data_t bl);
    cfg_idx_t  idxs[4];
    cfg_data_t vals[4];
    idxs = '{REG_ROTATE, REG_COS, REG_SIN, REG_BLOCK};
    vals = '{rot, cs, sn, bl};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index <= idxs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.write_reg(idxs[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, rx_idle_max);
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_mixed(out_i, out_q);
    end
  end

  initial begin : stimulus
    cfg_data_t rot_d, cs_d, sn_d, bl_d;
    longint    sn_l, cs_l;
    int        kind;
    tracker = new();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_sample_i <= '0;
    in_sample_q <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_ROTATE;
    cfg_data    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: identity phasor
    feed(16'sh7FFF, 16'sh8000);
    feed(16'sh8000, 16'sh7FFF);
    feed(16'sh0000, 16'sh0000);
    feed(-16'sd1, 16'sd1);
    end_phase(1'b1);

    // quarter-turn step, zero block length renormalizes every item
    program_regs(32'd1, 32'h0000_0000, 32'h4000_0000, 32'd0);
    feed(16'sh8000, 16'sh8000);
    feed(16'sh8000, 16'sh8000);
    feed(16'sh7FFF, 16'sh7FFF);
    feed(16'sd1, -16'sd1);
    feed(16'sh8000, 16'sh0000);
    end_phase(1'b1);

    // eighth-turn step drives outputs into saturation
    program_regs(32'd1, 32'h2D41_3CCD, 32'h2D41_3CCD, 32'd1);
    feed(16'sh8000, 16'sh8000);
    feed(16'sh8000, 16'sh8000);
    feed(16'sh7FFF, 16'sh8000);
    feed(16'sd1, 16'sd1);
    end_phase(1'b1);

    // zero step collapses the phasor to zero magnitude
    program_regs(32'd1, 32'h0000_0000, 32'h0000_0000, 32'd2);
    feed(16'sd1000, -16'sd1000);
    feed(16'sh7FFF, 16'sh7FFF);
    feed(-16'sd5, 16'sd7);
    feed(16'sd123, -16'sd456);
    end_phase(1'b1);

    // pass-through with the longest block
    program_regs(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h00FF_FFFF);
    feed(16'sh7FFF, 16'sh8000);
    feed(16'sh8000, 16'sh7FFF);
    feed(16'sh0000, -16'sd1);
    end_phase(1'b1);

    // extreme steps saturate the phasor
    program_regs(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3);
    feed(16'sh7FFF, 16'sh7FFF);
    feed(16'sh8000, 16'sd1);
    feed(16'sd100, -16'sd100);
    feed(-16'sd1, -16'sd1);
    end_phase(1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      kind = $urandom_range(0, 9);
      sn_l = $urandom_range(0, 33554432);
      sn_l = sn_l - 16777216;
      cs_l = (longint'(1) <<< FRAC_BITS) - ((sn_l * sn_l) >>> 31);
      cs_d = cfg_data_t'(cs_l);
      sn_d = cfg_data_t'(sn_l);
      if (kind == 1) begin
        cs_d = $urandom;
        sn_d = $urandom;
      end else if (kind == 2) begin
        cs_d = STEP_EXTREMES[$urandom_range(0, 5)];
        sn_d = STEP_EXTREMES[$urandom_range(0, 5)];
      end
      rot_d    = $urandom;
      rot_d[0] = (kind != 0);
      case ($urandom_range(0, 5))
        0: bl_d = 32'd0;
        1: bl_d = 32'd1;
        2: bl_d = $urandom_range(2, 8);
        3: bl_d = $urandom_range(9, 64);
        4: bl_d = 32'h00FF_FFFF;
        default: bl_d = $urandom_range(65, 4800);
      endcase
      bl_d[31:24] = 8'($urandom);
      tx_idle_max = (p % 2 != 0) ? 4 : 0;
      rx_idle_max = (p % 3 == 0) ? 0 : 4;
      program_regs(rot_d, cs_d, sn_d, bl_d);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 3 && n == 10) rx_hold = LONG_HOLD;
        if (p == 5 && n == 28) end_phase(1'b0);
        feed(rand_sample(), rand_sample());
      end
      end_phase(1'b1);
    end

    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
